// ===== sv/alpe_pkg.sv =====
package alpe_pkg;

  // action codes on the input side
  typedef enum logic [1:0] {
    ACT_SET_PIXEL = 2'd0,
    ACT_REFRESH   = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_TICK      = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [1:0] CFG_HIGH_DUTY     = 2'd0;
  localparam logic [1:0] CFG_LOW_DUTY      = 2'd1;
  localparam logic [1:0] CFG_RESET_SLOTS   = 2'd2;
  localparam logic [1:0] CFG_PIXELS_IN_USE = 2'd3;

  // register reset values
  localparam logic [7:0] HIGH_DUTY_RST     = 8'd70;
  localparam logic [7:0] LOW_DUTY_RST      = 8'd35;
  localparam logic [7:0] RESET_SLOTS_RST   = 8'd50;
  localparam logic [6:0] PIXELS_IN_USE_RST = 7'd64;

  localparam int BITS_PER_PIXEL = 24;

  // one classified request waiting in the queue
  typedef struct packed {
    action_t     action;
    logic        in_range;
    logic [7:0]  pixel_index;
    logic [23:0] color;       // green, red, blue from the top bit down
  } queue_item_t;

  // configuration write
  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

// ===== sv/alpe_front.sv =====
module alpe_front #(
  parameter int PIXEL_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [1:0]            s_tuser,
  output logic                  q_valid,
  output alpe_pkg::queue_item_t q_item,
  input  logic                  q_pop
);

  alpe_pkg::queue_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  alpe_pkg::queue_item_t incoming;

  // classify the incoming request
  always_comb begin
    incoming.action      = alpe_pkg::action_t'(s_tuser);
    incoming.pixel_index = s_tdata[7:0];
    incoming.in_range    = ({1'b0, s_tdata[7:0]} < 9'(PIXEL_DEPTH));
    incoming.color       = {s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]};
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= incoming;
  end

endmodule

// ===== sv/alpe_back.sv =====
module alpe_back #(
  parameter int PIXEL_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  alpe_pkg::queue_item_t q_item,
  output logic                  q_pop,
  input  alpe_pkg::cfg_wr_t     cfg,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast,
  output logic [2:0]            m_tuser
);

  localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
  localparam int CW = $clog2(PIXEL_DEPTH + 1);

  // configuration registers
  logic [7:0] high_duty, low_duty, reset_slots;
  logic [6:0] pixels_in_use;

  // frame state
  logic [7:0]             frame_high, frame_low, frame_latch;
  logic [CW-1:0]          frame_pixels;
  logic                   sending;
  logic [CW-1:0]          pixel_position;
  logic [4:0]             bit_position;
  logic                   in_latch_phase;
  logic [7:0]             latch_count;
  logic [PIXEL_DEPTH-1:0] pixel_written;

  logic [23:0] pixel_store [PIXEL_DEPTH];

  // next values
  logic          sending_next, in_latch_phase_next;
  logic [CW-1:0] pixel_position_next;
  logic [4:0]    bit_position_next;
  logic [7:0]    latch_count_next;
  logic          capture, clear_all, store_wr;
  logic [CW-1:0] sat_pixels;
  logic          slot, last, rej, data_slot;

  // output stage
  logic        out_valid, out_slot, out_last, out_busy, out_rej, out_data_slot;
  logic        out_pix_ok;
  logic [7:0]  out_high, out_low;
  logic [4:0]  out_sel;
  logic [23:0] rd_color;
  logic        advance;
  logic [AW-1:0] rd_addr;
  logic        out_bit;

  assign advance = q_valid && (!out_valid || m_tready);
  assign q_pop   = advance;
  assign rd_addr = pixel_position[AW-1:0];

  assign sat_pixels = ({2'b00, pixels_in_use} > 9'(PIXEL_DEPTH)) ?
                      CW'(PIXEL_DEPTH) : CW'(pixels_in_use);

  // request execution
  always_comb begin
    sending_next        = sending;
    in_latch_phase_next = in_latch_phase;
    pixel_position_next = pixel_position;
    bit_position_next   = bit_position;
    latch_count_next    = latch_count;
    capture   = 1'b0;
    clear_all = 1'b0;
    store_wr  = 1'b0;
    slot      = 1'b0;
    last      = 1'b0;
    rej       = 1'b0;
    data_slot = 1'b0;
    if (q_item.action == alpe_pkg::ACT_TICK) begin
      if (sending) begin
        slot = 1'b1;
        if (!in_latch_phase) begin
          data_slot = 1'b1;
          if (bit_position == 5'(alpe_pkg::BITS_PER_PIXEL - 1)) begin
            bit_position_next   = 5'd0;
            pixel_position_next = pixel_position + CW'(1);
            if ((CW+1)'(pixel_position) + (CW+1)'(1) >= (CW+1)'(frame_pixels)) begin
              in_latch_phase_next = 1'b1;
              if (frame_latch == 8'd0) begin
                last         = 1'b1;
                sending_next = 1'b0;
              end
            end
          end else begin
            bit_position_next = bit_position + 5'd1;
          end
        end else begin
          latch_count_next = latch_count + 8'd1;
          if ({1'b0, latch_count} + 9'd1 >= {1'b0, frame_latch}) begin
            last         = 1'b1;
            sending_next = 1'b0;
          end
        end
      end
    end else if (sending) begin
      rej = 1'b1;
    end else begin
      unique case (q_item.action)
        alpe_pkg::ACT_SET_PIXEL: store_wr = q_item.in_range;
        alpe_pkg::ACT_CLEAR:     clear_all = 1'b1;
        default: begin
          capture             = 1'b1;
          pixel_position_next = '0;
          bit_position_next   = 5'd0;
          latch_count_next    = 8'd0;
          in_latch_phase_next = (sat_pixels == '0);
          sending_next        = !((sat_pixels == '0) && (reset_slots == 8'd0));
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_duty      <= alpe_pkg::HIGH_DUTY_RST;
      low_duty       <= alpe_pkg::LOW_DUTY_RST;
      reset_slots    <= alpe_pkg::RESET_SLOTS_RST;
      pixels_in_use  <= alpe_pkg::PIXELS_IN_USE_RST;
      sending        <= 1'b0;
      pixel_position <= '0;
      bit_position   <= 5'd0;
      in_latch_phase <= 1'b0;
      latch_count    <= 8'd0;
      pixel_written  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          alpe_pkg::CFG_HIGH_DUTY:     high_duty     <= cfg.data;
          alpe_pkg::CFG_LOW_DUTY:      low_duty      <= cfg.data;
          alpe_pkg::CFG_RESET_SLOTS:   reset_slots   <= cfg.data;
          alpe_pkg::CFG_PIXELS_IN_USE: pixels_in_use <= cfg.data[6:0];
          default:                     high_duty     <= high_duty;
        endcase
      end
      if (advance) begin
        sending        <= sending_next;
        pixel_position <= pixel_position_next;
        bit_position   <= bit_position_next;
        in_latch_phase <= in_latch_phase_next;
        latch_count    <= latch_count_next;
        if (clear_all) pixel_written <= '0;
        else if (store_wr) pixel_written[q_item.pixel_index[AW-1:0]] <= 1'b1;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame capture and result payload
  always_ff @(posedge clk) begin
    if (advance && capture) begin
      frame_high   <= high_duty;
      frame_low    <= low_duty;
      frame_latch  <= reset_slots;
      frame_pixels <= sat_pixels;
    end
    if (advance) begin
      out_slot      <= slot;
      out_last      <= last;
      out_busy      <= sending_next;
      out_rej       <= rej;
      out_data_slot <= data_slot;
      out_high      <= frame_high;
      out_low       <= frame_low;
      out_sel       <= 5'(alpe_pkg::BITS_PER_PIXEL - 1) - bit_position;
      out_pix_ok    <= pixel_written[rd_addr];
    end
  end

  // pixel store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (advance && store_wr) pixel_store[q_item.pixel_index[AW-1:0]] <= q_item.color;
    if (advance) rd_color <= pixel_store[rd_addr];
  end

  // duty for the slot from the fetched color bit
  assign out_bit  = out_pix_ok && rd_color[out_sel];
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data_slot ? (out_bit ? out_high : out_low) : 8'd0;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_rej, out_busy, out_slot};

endmodule

// ===== sv/addressable_led_pwm_encoder.sv =====
// channel   direction  handshake            tdata / tuser / tlast
// s_*       in         s_tvalid, s_tready   tdata: pixel_index, red, green, blue; tuser: action
// m_*       out        m_tvalid, m_tready   tdata: duty; tlast: last_slot;
//                                           tuser: slot_valid, busy_res, rejected
// cfg_*     in         cfg_we               cfg_index selects register, cfg_data value
//
// one request per cycle sustained while m_tready stays high; a request taken is written
// into the two-entry queue, then executed and its result registered in the output
// register that drives m_tvalid; the pixel store read is registered alongside the
// result. synchronous reset clears control state and valid marks at once; the pixel
// store itself is not cleared. while m_tready holds the result register, the two-entry
// queue takes two more requests and then drops s_tready.
module addressable_led_pwm_encoder #(
  parameter int PIXEL_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_index, red, green, blue
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // duty
  output logic        m_tlast,
  output logic [2:0]  m_tuser,   // slot_valid, busy_res, rejected
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                  q_valid;
  logic                  q_pop;
  alpe_pkg::queue_item_t q_item;
  alpe_pkg::cfg_wr_t     cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // request intake and classification
  alpe_front #(.PIXEL_DEPTH(PIXEL_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // frame sequencing and pixel store
  alpe_back #(.PIXEL_DEPTH(PIXEL_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== sv/alpe_checker.sv =====
module alpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [2:0] m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // frame end only on a sent slot
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("last without slot");

  // after the last slot the frame is over
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser[1])
    else $error("busy after last slot");

  // a refused request never sends a slot and comes only while busy
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> !m_tuser[0] && m_tuser[1])
    else $error("refusal with slot or while idle");

  // no slot means zero duty
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("duty without slot");

endmodule

bind addressable_led_pwm_encoder alpe_checker u_alpe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
